// ===== rtl/lislt_pkg.sv =====
// lislt_pkg: shared constants for the longest-increasing-run length tracker.
// Standalone; used by lis_length_tracker.
`default_nettype none

package lislt_pkg;

    localparam int unsigned MAX_LEN_DEFAULT = 1024;   // depth of the tail store
    localparam int unsigned VALUE_W         = 32;     // width of one sequence element
    localparam int unsigned LEN_OUT_W       = 11;     // width of the reported length

endpackage

`default_nettype wire

// ===== rtl/lislt_ram.sv =====
// lislt_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module lislt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lis_length_tracker.sv =====
// lis_length_tracker: top level; patience-sort length tracker over a tail RAM.
// Depends on lislt_pkg and lislt_ram.
`default_nettype none

// Each transfer on the item channel carries one signed value; the block returns one result
// per item: the length of the longest strictly increasing subsequence so far, the item's
// last flag, and a sticky flag set when a value was dropped because all MAX_LEN tails were
// in use. Internally the tails sit in one RAM and are binary-searched one probe at a time:
// each probe is a RAM read followed by a compare. An item is accepted, then probed until
// the search window closes, then the store and the result are updated once the output
// register is free. One item is worked at a time; the next may be taken while a result
// still waits in the output register. After a result with last set, the run length and
// the overflow flag clear. No clearing pass is needed after reset.
module lis_length_tracker #(
    parameter int unsigned MAX_LEN = lislt_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    item_valid,
    output logic                                         item_ready,
    input  wire logic signed [lislt_pkg::VALUE_W-1:0]    value,
    input  wire logic                                    last,
    output logic                                         result_valid,
    input  wire logic                                    result_ready,
    output logic             [lislt_pkg::LEN_OUT_W-1:0]  lis_length,
    output logic                                         done_res,
    output logic                                         overflow
);

    localparam int unsigned AW = $clog2(MAX_LEN);
    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned VW = lislt_pkg::VALUE_W;
    localparam int unsigned OW = lislt_pkg::LEN_OUT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_UPDATE
    } state_t;

    state_t                state_reg, state_next;
    logic signed [VW-1:0]  value_reg, value_next;
    logic                  last_reg, last_next;
    logic [LW-1:0]         lo_reg, lo_next;
    logic [LW-1:0]         hi_reg, hi_next;
    logic [LW-1:0]         run_len_reg, run_len_next;
    logic                  ovf_reg, ovf_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OW-1:0]         len_out_reg, len_out_next;
    logic                  done_out_reg, done_out_next;
    logic                  ovf_out_reg, ovf_out_next;

    logic [LW-1:0]         mid;
    logic [LW-1:0]         len_new;
    logic                  ovf_new;
    logic                  ram_we;
    logic                  ram_re;
    logic [VW-1:0]         ram_rdata;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    lislt_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_LEN)
    ) u_tails (
        .clk   (clk),
        .we    (ram_we),
        .waddr (lo_reg[AW-1:0]),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (mid[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign lis_length   = len_out_reg;
    assign done_res     = done_out_reg;
    assign overflow     = ovf_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        run_len_next   = run_len_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        len_out_next   = len_out_reg;
        done_out_next  = done_out_reg;
        ovf_out_next   = ovf_out_reg;
        len_new        = run_len_reg;
        ovf_new        = ovf_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    value_next = value;
                    last_next  = last;
                    lo_next    = '0;
                    hi_next    = run_len_reg;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_CMP:
            begin
                // lo/hi unchanged since the read, so mid still names the probed tail
                if ($signed(ram_rdata) < value_reg)
                begin
                    lo_next = mid + LW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = ST_SEARCH;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    if (lo_reg == run_len_reg)
                    begin
                        if (run_len_reg != LW'(MAX_LEN))
                        begin
                            ram_we  = 1'b1;
                            len_new = run_len_reg + LW'(1);
                        end
                        else
                        begin
                            ovf_new = 1'b1;
                        end
                    end
                    else
                    begin
                        // replace the first tail not below the value with the value
                        ram_we = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    len_out_next   = OW'(len_new);
                    done_out_next  = last_reg;
                    ovf_out_next   = ovf_new;
                    if (last_reg)
                    begin
                        run_len_next = '0;
                        ovf_next     = 1'b0;
                    end
                    else
                    begin
                        run_len_next = len_new;
                        ovf_next     = ovf_new;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_len_reg   <= run_len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        len_out_reg  <= len_out_next;
        done_out_reg <= done_out_next;
        ovf_out_reg  <= ovf_out_next;
    end

    // a RAM read is always followed by its compare
    a_read_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (state_reg == ST_CMP))
        else $error("tail read not followed by compare");

    // overflow can only be pending with a full store
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (run_len_reg == LW'(MAX_LEN)))
        else $error("overflow flag set with store not full");

    // search window stays ordered and within the run
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH || state_reg == ST_CMP)
            |-> (lo_reg <= hi_reg) && (hi_reg <= run_len_reg))
        else $error("search window out of order");

    // the store is written only when a result is loaded
    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("tail write without result");

    // the run never exceeds the store depth
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_len_reg <= LW'(MAX_LEN))
        else $error("run length beyond store depth");

endmodule

`default_nettype wire
